// ===== rtl/auto_exposure_program_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the exposure program core
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AUTO_EXPOSURE_PROGRAM_CORE_MACROS_SVH
`define AUTO_EXPOSURE_PROGRAM_CORE_MACROS_SVH

// same-cycle implication
`define AEP_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AEP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aep_pkg.sv =====
// ----------------------------------------------------------------------------
// aep_pkg
// Types, codes and fixed constants of the exposure program core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aep_pkg;

    // item op codes
    localparam logic [1:0] OP_MEASURE = 2'd0;
    localparam logic [1:0] OP_WR_AP   = 2'd1;
    localparam logic [1:0] OP_WR_SH   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // exposure modes (others run as auto)
    localparam logic [1:0] MODE_AUTO      = 2'd0;
    localparam logic [1:0] MODE_LANDSCAPE = 2'd1;
    localparam logic [1:0] MODE_PORTRAIT  = 2'd2;
    localparam logic [1:0] MODE_ALT_AUTO  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ISO    = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_FOCAL  = 3'd2;
    localparam logic [2:0] REG_AP_CNT = 3'd3;
    localparam logic [2:0] REG_SH_CNT = 3'd4;

    // register reset values
    localparam logic [16:0] ISO_RST   = 17'd100;
    localparam logic [10:0] FOCAL_RST = 11'd50;
    localparam logic [10:0] FOCAL_MIN = 11'd50;

    // default lens and camera limits
    localparam logic [15:0] F_DEF_WIDE  = 16'd358;
    localparam logic [15:0] F_DEF_SMALL = 16'd5632;
    localparam logic [15:0] F_TWO       = 16'd512;
    localparam logic [31:0] S_DEF_FAST  = 32'd16777;
    localparam logic [31:0] S_DEF_SLOW  = 32'd16777216;
    localparam logic [42:0] SLOW_LIMIT  = 43'd16777216;

    // auto mode aperture targets, Q8.8
    localparam logic [15:0] F_11  = 16'd2816;
    localparam logic [15:0] F_8   = 16'd2048;
    localparam logic [15:0] F_5P6 = 16'd1434;
    localparam logic [15:0] F_4   = 16'd1024;
    localparam logic [15:0] F_2P8 = 16'd717;

    // EV thresholds as lux*iso >= 250*2^k
    localparam logic [34:0] P_EV15 = 35'd8192000;
    localparam logic [34:0] P_EV12 = 35'd1024000;
    localparam logic [34:0] P_EV10 = 35'd256000;
    localparam logic [34:0] P_EV8  = 35'd64000;
    localparam logic [34:0] P_EV6  = 35'd16000;

    localparam logic [15:0] CAL_DIV = 16'd64000;

    // shared iterative unit geometry
    localparam int ARG_W   = 68;
    localparam int DEN_W   = 35;
    localparam int REM_W   = 36;
    localparam int ROOT_W  = 26;
    localparam int SQ_IN_W = 52;
    localparam logic [6:0] DIV_STEPS  = 7'd68;
    localparam logic [6:0] SQRT_STEPS = 7'd26;

    typedef enum logic {
        IT_DIV,
        IT_SQRT
    } t_iter_op;

    typedef struct packed {
        logic             start;
        t_iter_op         op;
        logic [ARG_W-1:0] arg;
        logic [DEN_W-1:0] den;
    } t_iter_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_RD_DONE,
        S_TARGET,
        S_SQ,
        S_NUM,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_PS_LO,
        S_PS_HI,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_FLAGS,
        S_SNAP,
        S_SNAP_TAIL,
        S_RESP
    } t_state;

endpackage

// ===== rtl/aep_stop_mem.sv =====
// ----------------------------------------------------------------------------
// aep_stop_mem
// Stop table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aep_stop_mem #(
    parameter int W     = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aep_iter_unit.sv =====
// ----------------------------------------------------------------------------
// aep_iter_unit
// Shared bit-serial unit: restoring divide, one quotient bit per cycle,
// or digit-by-digit square root, one root bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aep_iter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  aep_pkg::t_iter_req              i_req,
    output logic                            o_done,
    output logic [aep_pkg::ARG_W-1:0]       o_quo,
    output logic [aep_pkg::ROOT_W:0]        o_root
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [6:0]                   r_cnt, n_cnt;
    aep_pkg::t_iter_op            r_op, n_op;
    logic [aep_pkg::ARG_W-1:0]    r_num, n_num;
    logic [aep_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [aep_pkg::ROOT_W-1:0]   r_root, n_root;
    logic [aep_pkg::DEN_W-1:0]    r_den, n_den;

    logic [aep_pkg::REM_W-1:0]    sub_a;
    logic [aep_pkg::REM_W-1:0]    sub_b;
    logic [aep_pkg::REM_W:0]      diff;
    logic                         ge;
    logic                         round_up;

    // shared subtractor, operands picked by the running op
    assign sub_a = (r_op == aep_pkg::IT_DIV)
                 ? {r_rem[aep_pkg::REM_W-2:0], r_num[aep_pkg::ARG_W-1]}
                 : {r_rem[aep_pkg::REM_W-3:0], r_num[aep_pkg::ARG_W-1 -: 2]};
    assign sub_b = (r_op == aep_pkg::IT_DIV)
                 ? {1'b0, r_den}
                 : aep_pkg::REM_W'({r_root, 2'b01});
    assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge    = !diff[aep_pkg::REM_W];

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_num  = r_num;
        n_rem  = r_rem;
        n_root = r_root;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_rem  = '0;
            n_root = '0;
            n_den  = i_req.den;
            if (i_req.op == aep_pkg::IT_DIV) begin
                n_num = i_req.arg;
                n_cnt = aep_pkg::DIV_STEPS;
            end else begin
                n_num = {i_req.arg[aep_pkg::SQ_IN_W-1:0],
                         {(aep_pkg::ARG_W-aep_pkg::SQ_IN_W){1'b0}}};
                n_cnt = aep_pkg::SQRT_STEPS;
            end
        end else if (r_busy) begin
            n_rem = ge ? diff[aep_pkg::REM_W-1:0] : sub_a;
            if (r_op == aep_pkg::IT_DIV) begin
                n_num = {r_num[aep_pkg::ARG_W-2:0], ge};
            end else begin
                n_num  = {r_num[aep_pkg::ARG_W-3:0], 2'b00};
                n_root = {r_root[aep_pkg::ROOT_W-2:0], ge};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_den  <= n_den;
    end

    // nearest root: bump when remainder exceeds the floor root
    assign round_up = r_rem > aep_pkg::REM_W'(r_root);
    assign o_root   = {1'b0, r_root} + (aep_pkg::ROOT_W+1)'(round_up);
    assign o_quo    = r_num;
    assign o_done   = r_done;

endmodule

// ===== rtl/auto_exposure_program_core.sv =====
// ----------------------------------------------------------------------------
// auto_exposure_program_core
// Picks aperture and shutter time from a lux reading; loads the stop tables.
// A stop write, an ignored op or a zero lux or ISO value strobes o_done in the
// cycle after acceptance; a measure's time from acceptance to the result edge
// is set by the 68-step divider runs, the 26-step square root and the
// stop scans (one table entry per cycle). The receiver cannot stall.
// One item at a time: busy stays high from acceptance to o_done.
// Reset (i_rst_n low, synchronous) restores the state and configuration registers; tables keep data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module auto_exposure_program_core #(
    parameter int MAX_STOPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [17:0] i_lux_level,
    input  logic [5:0]  i_stop_index,
    input  logic [31:0] i_stop_value,
    // result strobe
    output logic        o_done,
    output logic [15:0] o_aperture_value,
    output logic [31:0] o_shutter_time,
    output logic        o_result_valid,
    output logic        o_over_exposed,
    output logic        o_under_exposed,
    output logic        o_shutter_clamped,
    output logic        o_aperture_at_limit,
    output logic        o_slow_shutter,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);

    aep_pkg::t_state r_state, n_state;

    // configuration registers
    logic [16:0] r_iso;
    logic [1:0]  r_mode;
    logic [10:0] r_focal;
    logic [6:0]  r_ap_cnt;
    logic [6:0]  r_sh_cnt;

    // working registers
    logic [34:0] r_p, n_p;
    logic [15:0] r_ap_e0, n_ap_e0;
    logic [31:0] r_sh_e0, n_sh_e0;
    logic [15:0] r_fw, n_fw;
    logic [15:0] r_fs, n_fs;
    logic [31:0] r_sf, n_sf;
    logic [31:0] r_ss, n_ss;
    logic [15:0] r_tf, n_tf;
    logic [31:0] r_ts, n_ts;
    logic [66:0] r_mul, n_mul;
    logic        r_fast, n_fast;
    logic        r_valid, n_valid;
    logic        r_over, n_over;
    logic        r_under, n_under;
    logic        r_clamped, n_clamped;
    logic        r_atlim, n_atlim;
    logic        r_slow, n_slow;
    logic [AW-1:0] r_idx, n_idx;
    logic        r_pend, n_pend;
    logic        r_snap_sh, n_snap_sh;
    logic [32:0] r_bd, n_bd;
    logic [31:0] r_best, n_best;

    // table ports
    logic          accept;
    logic          idx_ok;
    logic          ap_we, sh_we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [15:0]   ap_rdata;
    logic [31:0]   sh_rdata;

    // effective counts and last entries
    logic [CW-1:0] na, ns;
    logic [AW-1:0] ap_last, sh_last, scan_last;

    // shared unit
    aep_pkg::t_iter_req       it_req;
    logic                     it_done;
    logic [aep_pkg::ARG_W-1:0] it_quo;
    logic [aep_pkg::ROOT_W:0]  it_root;

    // target and snap helpers
    logic [15:0] tf_pick;
    logic [15:0] tf_clamp;
    logic [10:0] foc;
    logic [31:0] snap_t, snap_v, snap_d;
    logic        snap_better;
    logic [32:0] bd_next;
    logic [31:0] best_next;

    assign accept      = start && !busy;
    assign idx_ok      = int'(i_stop_index) < MAX_STOPS;
    assign ap_we       = accept && (i_op == aep_pkg::OP_WR_AP) && idx_ok;
    assign sh_we       = accept && (i_op == aep_pkg::OP_WR_SH) && idx_ok;
    assign waddr       = AW'(i_stop_index);
    assign o_cfg_ready = 1'b1;

    assign na = (int'(r_ap_cnt) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_ap_cnt);
    assign ns = (int'(r_sh_cnt) > MAX_STOPS) ? CW'(MAX_STOPS) : CW'(r_sh_cnt);
    assign ap_last   = AW'(na - CW'(1));
    assign sh_last   = AW'(ns - CW'(1));
    assign scan_last = r_snap_sh ? sh_last : ap_last;

    // table read address by phase
    always_comb begin
        case (r_state)
            aep_pkg::S_RD_LAST: raddr = ap_last;
            aep_pkg::S_SNAP:    raddr = r_idx;
            default:            raddr = '0;
        endcase
    end

    aep_stop_mem #(.W(16), .DEPTH(MAX_STOPS)) u_ap_mem (
        .i_clk   (i_clk),
        .i_we    (ap_we),
        .i_waddr (waddr),
        .i_wdata (i_stop_value[15:0]),
        .i_raddr (raddr),
        .o_rdata (ap_rdata)
    );

    aep_stop_mem #(.W(32), .DEPTH(MAX_STOPS)) u_sh_mem (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (waddr),
        .i_wdata (i_stop_value),
        .i_raddr ((r_state == aep_pkg::S_RD_LAST) ? sh_last : raddr),
        .o_rdata (sh_rdata)
    );

    aep_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (it_req),
        .o_done  (it_done),
        .o_quo   (it_quo),
        .o_root  (it_root)
    );

    // mode target, then lens clamp
    always_comb begin
        if (r_mode == aep_pkg::MODE_LANDSCAPE) begin
            tf_pick = aep_pkg::F_11;
        end else if (r_mode == aep_pkg::MODE_PORTRAIT) begin
            tf_pick = (r_fw < aep_pkg::F_TWO) ? aep_pkg::F_TWO : r_fw;
        end else if (r_p >= aep_pkg::P_EV15) begin
            tf_pick = aep_pkg::F_11;
        end else if (r_p >= aep_pkg::P_EV12) begin
            tf_pick = aep_pkg::F_8;
        end else if (r_p >= aep_pkg::P_EV10) begin
            tf_pick = aep_pkg::F_5P6;
        end else if (r_p >= aep_pkg::P_EV8) begin
            tf_pick = aep_pkg::F_4;
        end else if (r_p >= aep_pkg::P_EV6) begin
            tf_pick = aep_pkg::F_2P8;
        end else begin
            tf_pick = r_fw;
        end
        tf_clamp = (tf_pick < r_fw) ? r_fw : tf_pick;
        if (tf_clamp > r_fs) begin
            tf_clamp = r_fs;
        end
    end

    assign foc = (r_focal < aep_pkg::FOCAL_MIN) ? aep_pkg::FOCAL_MIN : r_focal;

    // nearest-stop compare, lowest index wins ties
    assign snap_t      = r_snap_sh ? sh_rdata : 32'(ap_rdata);
    assign snap_v      = r_snap_sh ? r_ts : 32'(r_tf);
    assign snap_d      = (snap_t > snap_v) ? (snap_t - snap_v) : (snap_v - snap_t);
    assign snap_better = {1'b0, snap_d} < r_bd;
    assign bd_next     = snap_better ? {1'b0, snap_d} : r_bd;
    assign best_next   = snap_better ? snap_t : r_best;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_p       = r_p;
        n_ap_e0   = r_ap_e0;
        n_sh_e0   = r_sh_e0;
        n_fw      = r_fw;
        n_fs      = r_fs;
        n_sf      = r_sf;
        n_ss      = r_ss;
        n_tf      = r_tf;
        n_ts      = r_ts;
        n_mul     = r_mul;
        n_fast    = r_fast;
        n_valid   = r_valid;
        n_over    = r_over;
        n_under   = r_under;
        n_clamped = r_clamped;
        n_atlim   = r_atlim;
        n_slow    = r_slow;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_snap_sh = r_snap_sh;
        n_bd      = r_bd;
        n_best    = r_best;
        it_req.start = 1'b0;
        it_req.op    = aep_pkg::IT_DIV;
        it_req.arg   = aep_pkg::ARG_W'(r_mul);
        it_req.den   = r_p;

        case (r_state)
            aep_pkg::S_IDLE: begin
                if (accept) begin
                    n_tf      = '0;
                    n_ts      = '0;
                    n_valid   = 1'b0;
                    n_over    = 1'b0;
                    n_under   = 1'b0;
                    n_clamped = 1'b0;
                    n_atlim   = 1'b0;
                    n_slow    = 1'b0;
                    n_p       = 35'(i_lux_level) * 35'(r_iso);
                    if (i_op == aep_pkg::OP_MEASURE && i_lux_level != '0 && r_iso != '0) begin
                        n_valid = 1'b1;
                        n_state = aep_pkg::S_RD_FIRST;
                    end else begin
                        n_state = aep_pkg::S_RESP;
                    end
                end
            end
            aep_pkg::S_RD_FIRST: begin
                n_state = aep_pkg::S_RD_LAST;
            end
            aep_pkg::S_RD_LAST: begin
                n_ap_e0 = ap_rdata;
                n_sh_e0 = sh_rdata;
                n_state = aep_pkg::S_RD_DONE;
            end
            aep_pkg::S_RD_DONE: begin
                n_fw = (na != '0) ? r_ap_e0 : aep_pkg::F_DEF_WIDE;
                n_fs = (na != '0) ? ap_rdata : aep_pkg::F_DEF_SMALL;
                if (ns != '0) begin
                    n_sf = (r_sh_e0 < sh_rdata) ? r_sh_e0 : sh_rdata;
                    n_ss = (r_sh_e0 < sh_rdata) ? sh_rdata : r_sh_e0;
                end else begin
                    n_sf = aep_pkg::S_DEF_FAST;
                    n_ss = aep_pkg::S_DEF_SLOW;
                end
                n_state = aep_pkg::S_TARGET;
            end
            aep_pkg::S_TARGET: begin
                n_tf    = tf_clamp;
                n_state = aep_pkg::S_SQ;
            end
            aep_pkg::S_SQ: begin
                n_mul   = 67'(32'(r_tf) * 32'(r_tf));
                n_state = aep_pkg::S_NUM;
            end
            aep_pkg::S_NUM: begin
                // F*F*64000 plus half the divisor for rounding
                n_mul   = 67'(48'(r_mul[31:0]) * 48'(aep_pkg::CAL_DIV)) + 67'(r_p >> 1);
                n_state = aep_pkg::S_DIV1_GO;
            end
            aep_pkg::S_DIV1_GO: begin
                it_req.start = 1'b1;
                n_state      = aep_pkg::S_DIV1_WAIT;
            end
            aep_pkg::S_DIV1_WAIT: begin
                if (it_done) begin
                    if (it_quo < aep_pkg::ARG_W'(r_sf)) begin
                        n_ts      = r_sf;
                        n_clamped = 1'b1;
                        n_fast    = 1'b1;
                        n_state   = aep_pkg::S_PS_LO;
                    end else if (it_quo > aep_pkg::ARG_W'(r_ss)) begin
                        n_ts      = r_ss;
                        n_clamped = 1'b1;
                        n_fast    = 1'b0;
                        if (r_ss == '0) begin
                            n_tf    = r_fw;
                            n_under = 1'b1;
                            n_state = aep_pkg::S_FLAGS;
                        end else begin
                            n_state = aep_pkg::S_PS_LO;
                        end
                    end else begin
                        n_ts    = it_quo[31:0];
                        n_state = aep_pkg::S_FLAGS;
                    end
                end
            end
            aep_pkg::S_PS_LO: begin
                // P*S in two partial products
                n_mul   = 67'(51'(r_p) * 51'(r_ts[15:0]));
                n_state = aep_pkg::S_PS_HI;
            end
            aep_pkg::S_PS_HI: begin
                n_mul   = r_mul + (67'(51'(r_p) * 51'(r_ts[31:16])) << 16);
                n_state = aep_pkg::S_DIV2_GO;
            end
            aep_pkg::S_DIV2_GO: begin
                it_req.start = 1'b1;
                it_req.den   = aep_pkg::DEN_W'(aep_pkg::CAL_DIV);
                n_state      = aep_pkg::S_DIV2_WAIT;
            end
            aep_pkg::S_DIV2_WAIT: begin
                if (it_done) begin
                    n_state = aep_pkg::S_SQRT_GO;
                end
            end
            aep_pkg::S_SQRT_GO: begin
                it_req.start = 1'b1;
                it_req.op    = aep_pkg::IT_SQRT;
                it_req.arg   = it_quo;
                n_state      = aep_pkg::S_SQRT_WAIT;
            end
            aep_pkg::S_SQRT_WAIT: begin
                if (it_done) begin
                    if (it_root > (aep_pkg::ROOT_W+1)'(r_fs)) begin
                        n_tf   = r_fs;
                        n_over = 1'b1;
                    end else if (!r_fast && it_root < (aep_pkg::ROOT_W+1)'(r_fw)) begin
                        n_tf    = r_fw;
                        n_under = 1'b1;
                    end else begin
                        n_tf = it_root[15:0];
                    end
                    n_state = aep_pkg::S_FLAGS;
                end
            end
            aep_pkg::S_FLAGS: begin
                n_slow  = (43'(r_ts) * 43'(foc)) > aep_pkg::SLOW_LIMIT;
                n_atlim = (r_tf == r_fw) || (r_tf == r_fs);
                n_idx   = '0;
                n_pend  = 1'b0;
                n_bd    = '1;
                if (na != '0) begin
                    n_snap_sh = 1'b0;
                    n_state   = aep_pkg::S_SNAP;
                end else if (ns != '0) begin
                    n_snap_sh = 1'b1;
                    n_state   = aep_pkg::S_SNAP;
                end else begin
                    n_state = aep_pkg::S_RESP;
                end
            end
            aep_pkg::S_SNAP: begin
                // issue one read a cycle; compare the data of the previous one
                n_pend = 1'b1;
                if (r_pend) begin
                    n_bd   = bd_next;
                    n_best = best_next;
                end
                if (r_idx == scan_last) begin
                    n_state = aep_pkg::S_SNAP_TAIL;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            aep_pkg::S_SNAP_TAIL: begin
                n_idx  = '0;
                n_pend = 1'b0;
                n_bd   = '1;
                if (!r_snap_sh) begin
                    n_tf = best_next[15:0];
                    if (ns != '0) begin
                        n_snap_sh = 1'b1;
                        n_state   = aep_pkg::S_SNAP;
                    end else begin
                        n_state = aep_pkg::S_RESP;
                    end
                end else begin
                    n_ts    = best_next;
                    n_state = aep_pkg::S_RESP;
                end
            end
            aep_pkg::S_RESP: begin
                n_state = aep_pkg::S_IDLE;
            end
            default: begin
                n_state = aep_pkg::S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= aep_pkg::S_IDLE;
            r_iso    <= aep_pkg::ISO_RST;
            r_mode   <= aep_pkg::MODE_AUTO;
            r_focal  <= aep_pkg::FOCAL_RST;
            r_ap_cnt <= '0;
            r_sh_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    aep_pkg::REG_ISO:    r_iso    <= i_cfg_data[16:0];
                    aep_pkg::REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    aep_pkg::REG_FOCAL:  r_focal  <= i_cfg_data[10:0];
                    aep_pkg::REG_AP_CNT: r_ap_cnt <= i_cfg_data[6:0];
                    aep_pkg::REG_SH_CNT: r_sh_cnt <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_ap_e0   <= n_ap_e0;
        r_sh_e0   <= n_sh_e0;
        r_fw      <= n_fw;
        r_fs      <= n_fs;
        r_sf      <= n_sf;
        r_ss      <= n_ss;
        r_tf      <= n_tf;
        r_ts      <= n_ts;
        r_mul     <= n_mul;
        r_fast    <= n_fast;
        r_valid   <= n_valid;
        r_over    <= n_over;
        r_under   <= n_under;
        r_clamped <= n_clamped;
        r_atlim   <= n_atlim;
        r_slow    <= n_slow;
        r_idx     <= n_idx;
        r_pend    <= n_pend;
        r_snap_sh <= n_snap_sh;
        r_bd      <= n_bd;
        r_best    <= n_best;
    end

    // result ports
    assign busy                = (r_state != aep_pkg::S_IDLE);
    assign o_done              = (r_state == aep_pkg::S_RESP);
    assign o_aperture_value    = r_tf;
    assign o_shutter_time      = r_ts;
    assign o_result_valid      = r_valid;
    assign o_over_exposed      = r_over;
    assign o_under_exposed     = r_under;
    assign o_shutter_clamped   = r_clamped;
    assign o_aperture_at_limit = r_atlim;
    assign o_slow_shutter      = r_slow;

endmodule

// ===== rtl/aep_checker.sv =====
// ----------------------------------------------------------------------------
// aep_checker
// Port-level checks of the exposure program core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "auto_exposure_program_core_macros.svh"

module aep_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_aperture_value,
    input logic [31:0] o_shutter_time,
    input logic        o_result_valid,
    input logic        o_over_exposed,
    input logic        o_under_exposed,
    input logic        o_shutter_clamped,
    input logic        o_aperture_at_limit,
    input logic        o_slow_shutter
);

    // a transaction once taken keeps the core busy
    `AEP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept did not raise busy")

    // results only come out for a transaction in flight
    `AEP_ASSERT_IMM(a_done_busy, i_clk, i_rst_n, o_done, busy, "result strobe while idle")

    // core returns to idle after the result
    `AEP_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy after result strobe")

    // invalid results and write acks carry all zero fields
    `AEP_ASSERT_IMM(a_zero_ack, i_clk, i_rst_n, o_done && !o_result_valid, o_aperture_value == 16'd0 && o_shutter_time == 32'd0 && !o_over_exposed && !o_under_exposed && !o_shutter_clamped && !o_aperture_at_limit && !o_slow_shutter, "nonzero fields in invalid result")

    // over and under exposure never both
    `AEP_ASSERT_IMM(a_exp_excl, i_clk, i_rst_n, o_done, !(o_over_exposed && o_under_exposed), "over and under exposure together")

endmodule

bind auto_exposure_program_core aep_checker u_aep_checker (.*);
